@@ rtl/core/vts_pkg.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Vorticity transport stencil package
// Shared widths, codes, command and status types and saturation helper.
// ----------------------------------------------------------------------------
package vts_pkg;

    localparam int VAL_W    = 40;
    localparam int SCALE_W  = 32;
    localparam int COEF_W   = 32;
    localparam int MUL_W    = 44;
    localparam int PT_W     = 8;
    localparam int LN_W     = 10;
    localparam int ADDR_W   = PT_W + 1;
    localparam int CFG_IDX_W = 3;

    localparam logic [CFG_IDX_W-1:0] CFG_GRID_LINES   = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_LINE_POINTS  = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_ADV_COEF     = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_DIFF_LINE    = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_DIFF_POINT   = 3'd4;

    localparam logic signed [VAL_W-1:0] MAX40 = {1'b0, {(VAL_W-1){1'b1}}};
    localparam logic signed [VAL_W-1:0] MIN40 = {1'b1, {(VAL_W-1){1'b0}}};

    typedef enum logic [1:0] {
        RD_NEXT,
        RD_PREV,
        RD_OLD,
        RD_CENTER
    } rd_t;

    typedef enum logic [2:0] {
        OP_J1,
        OP_J2,
        OP_ADV,
        OP_DL,
        OP_DP,
        OP_INCR
    } op_t;

    typedef enum logic [1:0] {
        SHIFT_16,
        SHIFT_20,
        SHIFT_30
    } shift_t;

    typedef struct packed {
        logic take;
        logic rd_en;
        rd_t  rd_sel;
        logic cap_en;
        rd_t  cap_sel;
        logic mul_start;
        logic mul_store;
        op_t  mul_op;
        logic mem_write;
        logic load_out;
    } cmd_t;

    typedef struct packed {
        logic interior;
        logic mul_done;
        logic out_free;
    } status_t;

    // Clamp a wide signed value into the 40-bit signed range.
    function automatic logic signed [VAL_W-1:0] sat40(input logic signed [MUL_W-1:0] x);
        logic signed [VAL_W-1:0] r;
        if (x > MUL_W'(MAX40))
            r = MAX40;
        else if (x < MUL_W'(MIN40))
            r = MIN40;
        else
            r = x[VAL_W-1:0];
        return r;
    endfunction

endpackage

@@ rtl/core/vts_mul.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Vorticity transport multiplier
// Sign-magnitude multiply, 16 bits of the second operand per cycle, then a
// flooring right shift with saturation to 40 bits signed.
// ----------------------------------------------------------------------------
module vts_mul (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            start,
    input  logic signed [vts_pkg::MUL_W-1:0] op_a,
    input  logic signed [vts_pkg::MUL_W-1:0] op_b,
    input  vts_pkg::shift_t                 shift,
    output logic                            done,
    output logic signed [vts_pkg::VAL_W-1:0] result
);
    import vts_pkg::*;

    localparam int CHUNK_W = 16;
    localparam int UB_W    = 3 * CHUNK_W;
    localparam int ACC_W   = MUL_W + UB_W;
    localparam int PP_W    = MUL_W + CHUNK_W;

    logic                     busy_reg, busy_next;
    logic                     fin_reg, fin_next;
    logic                     done_reg, done_next;
    logic [1:0]               cnt_reg, cnt_next;
    logic                     neg_reg;
    logic [MUL_W-1:0]         ua_reg;
    logic [UB_W-1:0]          ub_reg;
    logic [ACC_W-1:0]         acc_reg, acc_next;
    shift_t                   sh_reg;
    logic signed [VAL_W-1:0]  res_reg, res_next;

    logic [CHUNK_W-1:0]       chunk;
    logic [PP_W-1:0]          pp;
    logic [ACC_W-1:0]         pp_sh;
    logic [ACC_W-1:0]         q;
    logic                     rem_nz;
    logic [VAL_W:0]           qp1;
    logic [MUL_W-1:0]         ua_in, ub_in;

    // Operand magnitudes.
    assign ua_in = op_a[MUL_W-1] ? MUL_W'(-op_a) : MUL_W'(op_a);
    assign ub_in = op_b[MUL_W-1] ? MUL_W'(-op_b) : MUL_W'(op_b);

    // One partial product per accumulation cycle.
    always_comb
    begin
        case (cnt_reg)
            2'd0:    chunk = ub_reg[CHUNK_W-1:0];
            2'd1:    chunk = ub_reg[2*CHUNK_W-1:CHUNK_W];
            default: chunk = ub_reg[3*CHUNK_W-1:2*CHUNK_W];
        endcase
        pp = PP_W'(ua_reg) * PP_W'(chunk);
        case (cnt_reg)
            2'd0:    pp_sh = ACC_W'(pp);
            2'd1:    pp_sh = ACC_W'(pp) << CHUNK_W;
            default: pp_sh = ACC_W'(pp) << (2 * CHUNK_W);
        endcase
    end

    // Flooring shift and saturation of the finished product.
    always_comb
    begin
        case (sh_reg)
            SHIFT_16:
            begin
                q      = acc_reg >> 16;
                rem_nz = |acc_reg[15:0];
            end
            SHIFT_20:
            begin
                q      = acc_reg >> 20;
                rem_nz = |acc_reg[19:0];
            end
            SHIFT_30:
            begin
                q      = acc_reg >> 30;
                rem_nz = |acc_reg[29:0];
            end
            default:
            begin
                q      = acc_reg;
                rem_nz = 1'b0;
            end
        endcase
        qp1 = (VAL_W+1)'(q) + (VAL_W+1)'(rem_nz);
        if (!neg_reg)
        begin
            if (q > ACC_W'(MAX40))
                res_next = MAX40;
            else
                res_next = q[VAL_W-1:0];
        end
        else
        begin
            if (q > (ACC_W'(1) << (VAL_W-1)) || qp1 > ((VAL_W+1)'(1) << (VAL_W-1)))
                res_next = MIN40;
            else
                res_next = VAL_W'(-qp1);
        end
    end

    // Sequencing of the unit.
    always_comb
    begin
        busy_next = busy_reg;
        fin_next  = 1'b0;
        done_next = 1'b0;
        cnt_next  = cnt_reg;
        acc_next  = acc_reg;
        if (start)
        begin
            busy_next = 1'b1;
            cnt_next  = 2'd0;
            acc_next  = '0;
        end
        else if (busy_reg)
        begin
            acc_next = acc_reg + pp_sh;
            cnt_next = cnt_reg + 2'd1;
            if (cnt_reg == 2'd2)
            begin
                busy_next = 1'b0;
                fin_next  = 1'b1;
            end
        end
        else if (fin_reg)
        begin
            done_next = 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            fin_reg  <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= 2'd0;
        end
        else
        begin
            busy_reg <= busy_next;
            fin_reg  <= fin_next;
            done_reg <= done_next;
            cnt_reg  <= cnt_next;
        end
    end

    // Operand and product registers.
    always_ff @(posedge clk)
    begin
        acc_reg <= acc_next;
        if (start)
        begin
            neg_reg <= op_a[MUL_W-1] ^ op_b[MUL_W-1];
            ua_reg  <= ua_in;
            ub_reg  <= UB_W'(ub_in);
            sh_reg  <= shift;
        end
        if (fin_reg)
            res_reg <= res_next;
    end

    assign done   = done_reg;
    assign result = res_reg;

endmodule

@@ rtl/core/vts_datapath.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Vorticity transport datapath
// Configuration, sweep counters, line buffers, operand selection, the shared
// multiplier and the output register.
// ----------------------------------------------------------------------------
module vts_datapath (
    input  logic                              clk,
    input  logic                              rst_n,
    input  vts_pkg::cmd_t                     cmd,
    output vts_pkg::status_t                  status,
    input  logic                              cfg_we,
    input  logic [vts_pkg::CFG_IDX_W-1:0]     cfg_index,
    input  logic [vts_pkg::COEF_W-1:0]        cfg_data,
    input  logic signed [vts_pkg::VAL_W-1:0]  in_stream,
    input  logic signed [vts_pkg::VAL_W-1:0]  in_vort,
    input  logic [vts_pkg::SCALE_W-1:0]       in_scale,
    input  logic                              in_frame_start,
    output logic                              out_valid,
    input  logic                              out_ready,
    output logic signed [vts_pkg::VAL_W-1:0]  out_vort,
    output logic [vts_pkg::LN_W-1:0]          out_line,
    output logic [vts_pkg::PT_W-1:0]          out_point,
    output logic                              out_last
);
    import vts_pkg::*;

    localparam int DEPTH = 2 ** ADDR_W;

    // Configuration registers.
    logic [10:0]         grid_lines_reg;
    logic [8:0]          line_points_reg;
    logic [COEF_W-1:0]   adv_coef_reg, diff_line_reg, diff_point_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            grid_lines_reg  <= 11'd401;
            line_points_reg <= 9'd201;
            adv_coef_reg    <= 32'd50947000;
            diff_line_reg   <= 32'd6254900;
            diff_point_reg  <= 32'd664030;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                CFG_GRID_LINES:  grid_lines_reg  <= cfg_data[10:0];
                CFG_LINE_POINTS: line_points_reg <= cfg_data[8:0];
                CFG_ADV_COEF:    adv_coef_reg    <= cfg_data;
                CFG_DIFF_LINE:   diff_line_reg   <= cfg_data;
                CFG_DIFF_POINT:  diff_point_reg  <= cfg_data;
                default:         ;
            endcase
        end
    end

    // Clamped grid sizes.
    logic [10:0] nl;
    logic [8:0]  np;

    always_comb
    begin
        if (grid_lines_reg < 11'd3)
            nl = 11'd3;
        else if (grid_lines_reg > 11'd1024)
            nl = 11'd1024;
        else
            nl = grid_lines_reg;
        if (line_points_reg < 9'd3)
            np = 9'd3;
        else if (line_points_reg > 9'd256)
            np = 9'd256;
        else
            np = line_points_reg;
    end

    // Sweep position of the arriving item.
    logic [LN_W-1:0]    line_cnt_reg, line_cnt_next;
    logic [PT_W-1:0]    point_cnt_reg, point_cnt_next;
    logic [SCALE_W-1:0] cur_scale_reg, prev_scale_reg, prev_scale_next;
    logic [LN_W-1:0]    ln;
    logic [PT_W-1:0]    pt;
    logic               interior_now, last_now;

    always_comb
    begin
        ln = in_frame_start ? '0 : line_cnt_reg;
        pt = in_frame_start ? '0 : point_cnt_reg;
        prev_scale_next = (pt == '0) ? cur_scale_reg : prev_scale_reg;
        interior_now = (ln >= LN_W'(2)) && (pt >= PT_W'(1))
                       && ((9'(pt) + 9'd2) <= np) && (pt != {PT_W{1'b1}});
        last_now = ((11'(ln) + 11'd1) == nl) && ((9'(pt) + 9'd2) == np);
        if ((9'(pt) + 9'd1) >= np)
        begin
            point_cnt_next = '0;
            line_cnt_next  = ((11'(ln) + 11'd1) >= nl) ? '0 : ln + LN_W'(1);
        end
        else
        begin
            point_cnt_next = pt + PT_W'(1);
            line_cnt_next  = ln;
        end
    end

    logic interior_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            line_cnt_reg   <= '0;
            point_cnt_reg  <= '0;
            cur_scale_reg  <= '0;
            prev_scale_reg <= '0;
            interior_reg   <= 1'b0;
        end
        else if (cmd.take)
        begin
            line_cnt_reg   <= line_cnt_next;
            point_cnt_reg  <= point_cnt_next;
            cur_scale_reg  <= in_scale;
            prev_scale_reg <= prev_scale_next;
            interior_reg   <= interior_now;
        end
    end

    // Item registers.
    logic signed [VAL_W-1:0] psi_reg, w_reg;
    logic [LN_W-1:0]         ln_reg;
    logic [PT_W-1:0]         pt_reg;
    logic                    last_reg;

    always_ff @(posedge clk)
    begin
        if (cmd.take)
        begin
            psi_reg  <= in_stream;
            w_reg    <= in_vort;
            ln_reg   <= ln;
            pt_reg   <= pt;
            last_reg <= last_now;
        end
    end

    // Line buffers, two lines each, addressed by line slot and point.
    logic [VAL_W-1:0]  stream_mem [0:DEPTH-1];
    logic [VAL_W-1:0]  vort_mem [0:DEPTH-1];
    logic [VAL_W-1:0]  stream_q_reg, vort_q_reg;
    logic [ADDR_W-1:0] rd_addr, wr_addr;
    logic              cur_slot, old_slot;

    assign old_slot = ln_reg[0];
    assign cur_slot = ~ln_reg[0];
    assign wr_addr  = {old_slot, pt_reg};

    always_comb
    begin
        case (cmd.rd_sel)
            RD_NEXT:   rd_addr = {cur_slot, pt_reg + PT_W'(1)};
            RD_PREV:   rd_addr = {cur_slot, pt_reg - PT_W'(1)};
            RD_OLD:    rd_addr = {old_slot, pt_reg};
            RD_CENTER: rd_addr = {cur_slot, pt_reg};
            default:   rd_addr = {cur_slot, pt_reg};
        endcase
    end

    always_ff @(posedge clk)
    begin
        if (cmd.mem_write)
        begin
            stream_mem[wr_addr] <= psi_reg;
            vort_mem[wr_addr]   <= w_reg;
        end
        if (cmd.rd_en)
        begin
            stream_q_reg <= stream_mem[rd_addr];
            vort_q_reg   <= vort_mem[rd_addr];
        end
    end

    // Stencil neighbors captured from the read port.
    logic signed [VAL_W-1:0] pn_reg, ps_reg, po_reg, wn_reg, ws_reg, wo_reg, wc_reg;

    always_ff @(posedge clk)
    begin
        if (cmd.cap_en)
        begin
            case (cmd.cap_sel)
                RD_NEXT:
                begin
                    pn_reg <= stream_q_reg;
                    wn_reg <= vort_q_reg;
                end
                RD_PREV:
                begin
                    ps_reg <= stream_q_reg;
                    ws_reg <= vort_q_reg;
                end
                RD_OLD:
                begin
                    po_reg <= stream_q_reg;
                    wo_reg <= vort_q_reg;
                end
                default:
                begin
                    wc_reg <= vort_q_reg;
                end
            endcase
        end
    end

    // Operand selection for the shared multiplier.
    logic signed [VAL_W-1:0] j1_reg, j2_reg, adv_reg, dl_reg, dp_reg, incr_reg;
    logic signed [MUL_W-1:0] op_a, op_b;
    shift_t                  op_shift;
    logic                    mul_done;
    logic signed [VAL_W-1:0] mul_res;

    always_comb
    begin
        case (cmd.mul_op)
            OP_J1:
            begin
                op_a     = MUL_W'(pn_reg) - MUL_W'(ps_reg);
                op_b     = MUL_W'(w_reg) - MUL_W'(wo_reg);
                op_shift = SHIFT_20;
            end
            OP_J2:
            begin
                op_a     = MUL_W'(psi_reg) - MUL_W'(po_reg);
                op_b     = MUL_W'(wn_reg) - MUL_W'(ws_reg);
                op_shift = SHIFT_20;
            end
            OP_ADV:
            begin
                op_a     = MUL_W'(sat40(MUL_W'(j2_reg) - MUL_W'(j1_reg)));
                op_b     = $signed(MUL_W'(adv_coef_reg));
                op_shift = SHIFT_16;
            end
            OP_DL:
            begin
                op_a     = MUL_W'(w_reg) + MUL_W'(wo_reg) - (MUL_W'(wc_reg) <<< 1);
                op_b     = $signed(MUL_W'(diff_line_reg));
                op_shift = SHIFT_16;
            end
            OP_DP:
            begin
                op_a     = MUL_W'(wn_reg) + MUL_W'(ws_reg) - (MUL_W'(wc_reg) <<< 1);
                op_b     = $signed(MUL_W'(diff_point_reg));
                op_shift = SHIFT_16;
            end
            default:
            begin
                op_a     = MUL_W'(sat40(MUL_W'(adv_reg) + MUL_W'(dl_reg) + MUL_W'(dp_reg)));
                op_b     = $signed(MUL_W'(prev_scale_reg));
                op_shift = SHIFT_30;
            end
        endcase
    end

    vts_mul u_mul (
        .clk    (clk),
        .rst_n  (rst_n),
        .start  (cmd.mul_start),
        .op_a   (op_a),
        .op_b   (op_b),
        .shift  (op_shift),
        .done   (mul_done),
        .result (mul_res)
    );

    // Store finished products.
    always_ff @(posedge clk)
    begin
        if (cmd.mul_store)
        begin
            case (cmd.mul_op)
                OP_J1:   j1_reg   <= mul_res;
                OP_J2:   j2_reg   <= mul_res;
                OP_ADV:  adv_reg  <= mul_res;
                OP_DL:   dl_reg   <= mul_res;
                OP_DP:   dp_reg   <= mul_res;
                default: incr_reg <= mul_res;
            endcase
        end
    end

    // Output register; it holds a result until the sink takes it.
    logic out_valid_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_valid_reg <= 1'b0;
        else if (cmd.load_out)
            out_valid_reg <= 1'b1;
        else if (out_ready)
            out_valid_reg <= 1'b0;
    end

    always_ff @(posedge clk)
    begin
        if (cmd.load_out)
        begin
            out_vort  <= sat40(MUL_W'(wc_reg) + MUL_W'(incr_reg));
            out_line  <= ln_reg - LN_W'(1);
            out_point <= pt_reg;
            out_last  <= last_reg;
        end
    end

    assign out_valid       = out_valid_reg;
    assign status.interior = interior_reg;
    assign status.mul_done = mul_done;
    assign status.out_free = !out_valid_reg || out_ready;

endmodule

@@ rtl/core/vts_ctrl.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Vorticity transport controller
// Steps an interior item through buffer reads, six products, write, output.
// ----------------------------------------------------------------------------
module vts_ctrl (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              in_valid,
    output logic              in_ready,
    input  vts_pkg::status_t  status,
    output vts_pkg::cmd_t     cmd
);
    import vts_pkg::*;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_CHECK,
        ST_RD_N,
        ST_RD_S,
        ST_RD_O,
        ST_RD_C,
        ST_CAP_C,
        ST_MUL_GO,
        ST_MUL_WAIT,
        ST_WRITE,
        ST_FIN
    } state_t;

    state_t state_reg, state_next;
    op_t    op_reg, op_next;

    // Next state and commands.
    always_comb
    begin
        state_next = state_reg;
        op_next    = op_reg;
        cmd        = '0;
        cmd.mul_op = op_reg;
        case (state_reg)
            ST_IDLE:
            begin
                if (in_valid)
                begin
                    cmd.take   = 1'b1;
                    state_next = ST_CHECK;
                end
            end
            ST_CHECK:
            begin
                state_next = status.interior ? ST_RD_N : ST_WRITE;
            end
            ST_RD_N:
            begin
                cmd.rd_en  = 1'b1;
                cmd.rd_sel = RD_NEXT;
                state_next = ST_RD_S;
            end
            ST_RD_S:
            begin
                cmd.rd_en   = 1'b1;
                cmd.rd_sel  = RD_PREV;
                cmd.cap_en  = 1'b1;
                cmd.cap_sel = RD_NEXT;
                state_next  = ST_RD_O;
            end
            ST_RD_O:
            begin
                cmd.rd_en   = 1'b1;
                cmd.rd_sel  = RD_OLD;
                cmd.cap_en  = 1'b1;
                cmd.cap_sel = RD_PREV;
                state_next  = ST_RD_C;
            end
            ST_RD_C:
            begin
                cmd.rd_en   = 1'b1;
                cmd.rd_sel  = RD_CENTER;
                cmd.cap_en  = 1'b1;
                cmd.cap_sel = RD_OLD;
                state_next  = ST_CAP_C;
            end
            ST_CAP_C:
            begin
                cmd.cap_en  = 1'b1;
                cmd.cap_sel = RD_CENTER;
                op_next     = OP_J1;
                state_next  = ST_MUL_GO;
            end
            ST_MUL_GO:
            begin
                cmd.mul_start = 1'b1;
                state_next    = ST_MUL_WAIT;
            end
            ST_MUL_WAIT:
            begin
                if (status.mul_done)
                begin
                    cmd.mul_store = 1'b1;
                    state_next    = ST_MUL_GO;
                    case (op_reg)
                        OP_J1:   op_next = OP_J2;
                        OP_J2:   op_next = OP_ADV;
                        OP_ADV:  op_next = OP_DL;
                        OP_DL:   op_next = OP_DP;
                        OP_DP:   op_next = OP_INCR;
                        default: state_next = ST_WRITE;
                    endcase
                end
            end
            ST_WRITE:
            begin
                cmd.mem_write = 1'b1;
                state_next    = status.interior ? ST_FIN : ST_IDLE;
            end
            ST_FIN:
            begin
                if (status.out_free)
                begin
                    cmd.load_out = 1'b1;
                    state_next   = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
            op_reg    <= OP_J1;
        end
        else
        begin
            state_reg <= state_next;
            op_reg    <= op_next;
        end
    end

    assign in_ready = (state_reg == ST_IDLE);

endmodule

@@ rtl/core/vorticity_transport_stencil.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Vorticity transport stencil
// One explicit vorticity step on a line-major grid stream with line buffers.
// ----------------------------------------------------------------------------
// An interior item passes from acceptance to the next acceptance through four
// line buffer reads on one read port and six products on one shared 44x16
// multiplier. A boundary item skips the reads and products and gives no result.
// A result is loaded into the output register once its products are done and waits
// there while the next item is taken; a full output register stalls the block.
// Reset (rst_n, asynchronous, active low) restores state, settings and counters only.
module vorticity_transport_stencil (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            s_axis_tvalid,
    output logic                            s_axis_tready,
    // stream_value [39:0], vorticity_value [79:40], line_scale [111:80]
    input  logic [111:0]                    s_axis_tdata,
    // frame_start
    input  logic                            s_axis_tuser,
    output logic                            m_axis_tvalid,
    input  logic                            m_axis_tready,
    // new_vorticity [39:0], line_index [49:40], point_index [57:50], zero fill
    output logic [63:0]                     m_axis_tdata,
    output logic                            m_axis_tlast,
    input  logic                            cfg_we,
    input  logic [vts_pkg::CFG_IDX_W-1:0]   cfg_index,
    input  logic [vts_pkg::COEF_W-1:0]      cfg_data
);
    import vts_pkg::*;

    cmd_t                    cmd;
    status_t                 status;
    logic signed [VAL_W-1:0] out_vort;
    logic [LN_W-1:0]         out_line;
    logic [PT_W-1:0]         out_point;

    vts_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (s_axis_tvalid),
        .in_ready (s_axis_tready),
        .status   (status),
        .cmd      (cmd)
    );

    vts_datapath u_datapath (
        .clk            (clk),
        .rst_n          (rst_n),
        .cmd            (cmd),
        .status         (status),
        .cfg_we         (cfg_we),
        .cfg_index      (cfg_index),
        .cfg_data       (cfg_data),
        .in_stream      ($signed(s_axis_tdata[39:0])),
        .in_vort        ($signed(s_axis_tdata[79:40])),
        .in_scale       (s_axis_tdata[111:80]),
        .in_frame_start (s_axis_tuser),
        .out_valid      (m_axis_tvalid),
        .out_ready      (m_axis_tready),
        .out_vort       (out_vort),
        .out_line       (out_line),
        .out_point      (out_point),
        .out_last       (m_axis_tlast)
    );

    assign m_axis_tdata = {6'd0, out_point, out_line, out_vort};

endmodule

@@ rtl/core/vts_checker.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Vorticity transport port checker
// Port-level properties of the stencil block, bound to the top level.
// ----------------------------------------------------------------------------
module vts_checker (
    input  logic         clk,
    input  logic         rst_n,
    input  logic         s_axis_tvalid,
    input  logic         s_axis_tready,
    input  logic         m_axis_tvalid,
    input  logic         m_axis_tready,
    input  logic [63:0]  m_axis_tdata,
    input  logic         m_axis_tlast
);

    // A held result keeps its contents.
    assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata)
        && $stable(m_axis_tlast))
        else $error("held result changed");

    // One item at a time: an accepted item closes the input for the next cycle.
    assert property (@(posedge clk) disable iff (!rst_n)
        s_axis_tvalid && s_axis_tready |=> !s_axis_tready)
        else $error("input open right after an accepted item");

    // Only interior points leave the block.
    assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid |-> m_axis_tdata[57:50] != 8'd0 && m_axis_tdata[57:50] != 8'd255
        && m_axis_tdata[49:40] != 10'd1023)
        else $error("boundary point emitted");

    // The fill bits above the fields stay zero.
    assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid |-> m_axis_tdata[63:58] == 6'd0)
        else $error("fill bits set");

endmodule

bind vorticity_transport_stencil vts_checker u_vts_checker (
    .clk           (clk),
    .rst_n         (rst_n),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tlast  (m_axis_tlast)
);

@@ test/vorticity_transport_stencil_test.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Vorticity transport stencil testbench
// Streams grid sweeps of several sizes and coefficient settings into the
// stencil, predicts each interior update in a local model and compares every
// output item field by field, with random gaps on input and stalls on output.
// ----------------------------------------------------------------------------
module vorticity_transport_stencil_test;

    import vts_pkg::*;

    localparam int LIMIT = 2000000;

    // Expected update for one interior centre point.
    typedef struct {
        logic [63:0] data;
        logic        last;
    } update_t;

    // Local model of the stencil and the store of pending updates.
    class vorticity_board;
        logic [10:0] grid_lines = 11'd401;
        logic [8:0]  line_points = 9'd201;
        logic [31:0] adv_coef = 32'd50947000;
        logic [31:0] diff_line = 32'd6254900;
        logic [31:0] diff_point = 32'd664030;
        logic signed [39:0] psi_buf [2][256];
        logic signed [39:0] vor_buf [2][256];
        logic [31:0] prev_scale = '0;
        logic [31:0] cur_scale = '0;
        int unsigned line_cnt = 0;
        int unsigned pt_cnt = 0;
        update_t pending_updates [$];
        int mismatches = 0;
        int updates_seen = 0;

        function void write_reg(logic [2:0] idx, logic [31:0] val);
            case (idx)
                CFG_GRID_LINES:  grid_lines = val[10:0];
                CFG_LINE_POINTS: line_points = val[8:0];
                CFG_ADV_COEF:    adv_coef = val;
                CFG_DIFF_LINE:   diff_line = val;
                CFG_DIFF_POINT:  diff_point = val;
                default: ;
            endcase
        endfunction

        function logic signed [39:0] clip40(logic signed [127:0] x);
            if (x > 128'sd549755813887)
                return MAX40;
            if (x < -128'sd549755813888)
                return MIN40;
            return x[39:0];
        endfunction

        // Product scaled down by 2^s, rounded toward minus infinity, then clipped.
        function logic signed [39:0] scaled_product(logic signed [127:0] a,
                                                    logic signed [127:0] b, int s);
            logic signed [127:0] p;
            p = a * b;
            return clip40(p >>> s);
        endfunction

        // Takes one accepted grid point and queues the update it completes.
        function void note_point(logic signed [39:0] psi, logic signed [39:0] w,
                                 logic [31:0] scale, logic frame_start);
            int unsigned np, nl, ln, pt, cur, old;
            logic signed [127:0] wc, wn, ws, wo, pn, ps, po, adv_sum, rhs;
            logic signed [39:0] j1, j2, adv, dl, dp, incr, nw;
            update_t u;
            np = line_points < 3 ? 3 : (line_points > 256 ? 256 : line_points);
            nl = grid_lines < 3 ? 3 : (grid_lines > 1024 ? 1024 : grid_lines);
            if (frame_start)
            begin
                line_cnt = 0;
                pt_cnt = 0;
            end
            ln = line_cnt;
            pt = pt_cnt % 256;
            if (pt == 0)
                prev_scale = cur_scale;
            cur_scale = scale;
            cur = (ln + 1) & 1;
            old = ln & 1;
            if (ln >= 2 && pt >= 1 && pt + 2 <= np && pt + 1 < 256)
            begin
                wc = vor_buf[cur][pt];
                wn = vor_buf[cur][pt + 1];
                ws = vor_buf[cur][pt - 1];
                wo = vor_buf[old][pt];
                pn = psi_buf[cur][pt + 1];
                ps = psi_buf[cur][pt - 1];
                po = psi_buf[old][pt];
                j1 = scaled_product(pn - ps, w - wo, 20);
                j2 = scaled_product(psi - po, wn - ws, 20);
                adv_sum = clip40(128'(j2) - 128'(j1));
                adv = scaled_product(adv_sum, {96'b0, adv_coef}, 16);
                dl = scaled_product(128'(w) + wo - 2 * wc, {96'b0, diff_line}, 16);
                dp = scaled_product(wn + ws - 2 * wc, {96'b0, diff_point}, 16);
                rhs = clip40(128'(adv) + dl + dp);
                incr = scaled_product(rhs, {96'b0, prev_scale}, 30);
                nw = clip40(wc + incr);
                u.data = {6'b0, 8'(pt), 10'(ln - 1), nw};
                u.last = (ln + 1 == nl && pt + 2 == np);
                pending_updates.push_back(u);
            end
            psi_buf[old][pt] = psi;
            vor_buf[old][pt] = w;
            if (pt_cnt + 1 >= np)
            begin
                pt_cnt = 0;
                line_cnt = (line_cnt + 1 >= nl) ? 0 : line_cnt + 1;
            end
            else
                pt_cnt = pt_cnt + 1;
        endfunction

        // Compares one output item with the oldest pending update.
        function void check_update(logic [63:0] data, logic last);
            update_t u;
            updates_seen++;
            if (pending_updates.size() == 0)
            begin
                mismatches++;
                if (mismatches <= 10)
                    $display("Unexpected output item: data %h last %b", data, last);
                return;
            end
            u = pending_updates.pop_front();
            if (data[39:0] !== u.data[39:0] || data[49:40] !== u.data[49:40]
                || data[57:50] !== u.data[57:50] || data[63:58] !== 6'b0
                || last !== u.last)
            begin
                mismatches++;
                if (mismatches <= 10)
                    $display("Mismatch: vort %h/%h line %0d/%0d point %0d/%0d last %b/%b",
                             u.data[39:0], data[39:0], u.data[49:40], data[49:40],
                             u.data[57:50], data[57:50], u.last, last);
            end
        endfunction
    endclass

    logic         clk;
    logic         rst_n;
    logic         s_axis_tvalid;
    logic         s_axis_tready;
    logic [111:0] s_axis_tdata;
    logic         s_axis_tuser;
    logic         m_axis_tvalid;
    logic         m_axis_tready;
    logic [63:0]  m_axis_tdata;
    logic         m_axis_tlast;
    logic         cfg_we;
    logic [CFG_IDX_W-1:0] cfg_index;
    logic [COEF_W-1:0]    cfg_data;

    vorticity_board board = new();
    int items_sent = 0;
    int burst_left = 0;
    int sweeps_run = 0;
    int cycles = 0;

    vorticity_transport_stencil DUT (.*);

    // Clock and cycle limit.
    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    always @(posedge clk)
    begin
        cycles <= cycles + 1;
        if (cycles > LIMIT)
        begin
            $display("Run exceeded its cycle limit.");
            $display("RESULT: ERROR");
            $finish;
        end
    end

    // Output side: stalls in a pattern that changes character over time.
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            m_axis_tready <= 1'b0;
        else if (cycles[12:11] == 2'd0)
            m_axis_tready <= 1'b1;
        else if (cycles[12:11] == 2'd1)
            m_axis_tready <= ($urandom_range(0, 3) != 0);
        else
            m_axis_tready <= (cycles[5:3] != 3'd0) && ($urandom_range(0, 9) != 0);
    end

    always @(posedge clk)
    begin
        if (rst_n && m_axis_tvalid && m_axis_tready)
            board.check_update(m_axis_tdata, m_axis_tlast);
    end

    // Sends one grid point; the sender works in bursts separated by gaps.
    task automatic send_point(logic [39:0] psi, logic [39:0] w, logic [31:0] scale,
                              logic fs);
        s_axis_tvalid <= 1'b1;
        s_axis_tdata <= {scale, w, psi};
        s_axis_tuser <= fs;
        do
            @(posedge clk);
        while (!s_axis_tready);
        board.note_point(psi, w, scale, fs);
        items_sent++;
        if (burst_left == 0)
        begin
            burst_left = $urandom_range(1, 60);
            if ($urandom_range(0, 3) != 0)
            begin
                s_axis_tvalid <= 1'b0;
                repeat ($urandom_range(1, 20)) @(posedge clk);
            end
        end
        else
            burst_left--;
    endtask

    // Waits until every pending update is out and the block has gone quiet.
    task automatic drain();
        s_axis_tvalid <= 1'b0;
        @(posedge clk);
        while (board.pending_updates.size() != 0)
            @(posedge clk);
        repeat (60) @(posedge clk);
    endtask

    task automatic write_reg(logic [2:0] idx, logic [31:0] val);
        cfg_we <= 1'b1;
        cfg_index <= idx;
        cfg_data <= val;
        @(posedge clk);
        cfg_we <= 1'b0;
        board.write_reg(idx, val);
    endtask

    function automatic logic [39:0] random_value();
        case ($urandom_range(0, 5))
            0: return 40'({$urandom, $urandom});
            1: return $urandom_range(0, 1) ? 40'h7F_FFFF_FFFF : 40'h80_0000_0000;
            default: return 40'($signed($urandom_range(0, 32'h1FF_FFFF)) - 32'sh100_0000);
        endcase
    endfunction

    function automatic logic [31:0] random_coef();
        case ($urandom_range(0, 7))
            0: return 32'h0;
            1: return 32'hFFFF_FFFF;
            2: return $urandom;
            default: return $urandom_range(0, 32'h0FFF_FFFF);
        endcase
    endfunction

    // Sends n random points; the first may start a sweep, others now and then.
    task automatic send_random(int n, logic start);
        for (int i = 0; i < n; i++)
            send_point(random_value(), random_value(), $urandom,
                       (i == 0 && start) || ($urandom_range(0, 199) == 0));
    endtask

    // Sets all registers for one phase.
    task automatic setup(logic [31:0] lines, logic [31:0] points, logic [31:0] a,
                         logic [31:0] dl, logic [31:0] dp);
        write_reg(CFG_GRID_LINES, lines);
        write_reg(CFG_LINE_POINTS, points);
        write_reg(CFG_ADV_COEF, a);
        write_reg(CFG_DIFF_LINE, dl);
        write_reg(CFG_DIFF_POINT, dp);
    endtask

    initial
    begin
        int nl, np;
        rst_n = 1'b0;
        s_axis_tvalid = 1'b0;
        s_axis_tdata = '0;
        s_axis_tuser = 1'b0;
        cfg_we = 1'b0;
        cfg_index = '0;
        cfg_data = '0;
        repeat (7) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Smallest grid, clamped from zero sizes, with extreme field values.
        setup(0, 0, 50947000, 6254900, 664030);
        send_point(40'h7F_FFFF_FFFF, 40'h80_0000_0000, 32'hFFFF_FFFF, 1'b1);
        send_point(40'h80_0000_0000, 40'h7F_FFFF_FFFF, 32'h0, 1'b0);
        send_point(40'h0, 40'h0, 32'hFFFF_FFFF, 1'b0);
        send_point(40'h7F_FFFF_FFFF, 40'h7F_FFFF_FFFF, 32'h4000_0000, 1'b0);
        send_point(40'h80_0000_0000, 40'h80_0000_0000, 32'h1234_5678, 1'b0);
        send_point(40'h00_0010_0000, 40'hFF_FFF0_0000, 32'hFFFF_FFFF, 1'b0);
        send_point(40'h7F_FFFF_FFFF, 40'h7F_FFFF_FFFF, 32'h8000_0000, 1'b0);
        send_point(40'h80_0000_0000, 40'h80_0000_0000, 32'hFFFF_FFFF, 1'b0);
        send_point(40'h00_0000_0001, 40'hFF_FFFF_FFFF, 32'h0000_0001, 1'b0);
        // Sweep wrap: the next sweep starts without a frame start mark.
        send_random(9, 1'b0);
        drain();

        // Largest values of all three coefficients.
        setup(3, 4, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
        send_random(12, 1'b1);
        drain();

        // Shrinking the line length mid-sweep past the point counter.
        setup(4, 6, 32'h0001_0000, 32'h0, 32'h0000_8000);
        send_random(15, 1'b1);
        drain();
        write_reg(CFG_LINE_POINTS, 3);
        send_random(12, 1'b0);
        drain();

        // One full-length line sweep, with the point count clamped from above.
        nl = 3;
        np = 256;
        setup(nl, 9'h1FF, random_coef(), random_coef(), random_coef());
        send_random(nl * np, 1'b1);
        sweeps_run++;
        drain();

        // Random phases, with an oversized line count now and then.
        while (items_sent < 1500)
        begin
            case ($urandom_range(0, 8))
                0:
                begin
                    nl = 10;
                    np = 3;
                    setup(11'h7FF, 3, random_coef(), random_coef(), random_coef());
                end
                default:
                begin
                    nl = $urandom_range(3, 6);
                    np = $urandom_range(3, 10);
                    setup(nl, np, random_coef(), random_coef(), random_coef());
                end
            endcase
            repeat ($urandom_range(1, 3))
            begin
                send_random(nl * np, 1'b1);
                sweeps_run++;
            end
            drain();
        end

        repeat (100) @(posedge clk);
        $display("Sent %0d grid points in %0d random sweeps; checked %0d updates.",
                 items_sent, sweeps_run, board.updates_seen);
        $display("Covered clamped and full-length sizes, extreme coefficients and a shrink.");
        if (board.mismatches == 0 && board.pending_updates.size() == 0)
            $display("RESULT: OK");
        else
        begin
            $display("%0d mismatches, %0d updates missing.", board.mismatches,
                     board.pending_updates.size());
            $display("RESULT: ERROR");
        end
        $finish;
    end

endmodule
